>>> design/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

>>> design/jtl_pkg.sv
package jtl_pkg;

	localparam int MODE_W = 4;

	localparam logic [MODE_W-1:0] M_IDLE  = 4'd0;
	localparam logic [MODE_W-1:0] M_LIT   = 4'd1;
	localparam logic [MODE_W-1:0] M_STR   = 4'd2;
	localparam logic [MODE_W-1:0] M_MINUS = 4'd3;
	localparam logic [MODE_W-1:0] M_ZERO  = 4'd4;
	localparam logic [MODE_W-1:0] M_INT   = 4'd5;
	localparam logic [MODE_W-1:0] M_DOT   = 4'd6;
	localparam logic [MODE_W-1:0] M_FRAC  = 4'd7;
	localparam logic [MODE_W-1:0] M_EXPE  = 4'd8;
	localparam logic [MODE_W-1:0] M_ESIGN = 4'd9;
	localparam logic [MODE_W-1:0] M_EXPD  = 4'd10;

	localparam logic [3:0] K_LBRACE = 4'd0;
	localparam logic [3:0] K_RBRACE = 4'd1;
	localparam logic [3:0] K_LBRACK = 4'd2;
	localparam logic [3:0] K_RBRACK = 4'd3;
	localparam logic [3:0] K_COLON  = 4'd4;
	localparam logic [3:0] K_COMMA  = 4'd5;
	localparam logic [3:0] K_TRUE   = 4'd6;
	localparam logic [3:0] K_FALSE  = 4'd7;
	localparam logic [3:0] K_NULL   = 4'd8;
	localparam logic [3:0] K_STRING = 4'd9;
	localparam logic [3:0] K_NUMBER = 4'd10;
	localparam logic [3:0] K_ERROR  = 4'd11;

	localparam logic [2:0] E_NONE      = 3'd0;
	localparam logic [2:0] E_BAD_START = 3'd1;
	localparam logic [2:0] E_BAD_LIT   = 3'd2;
	localparam logic [2:0] E_DIGIT     = 3'd3;
	localparam logic [2:0] E_SIGN      = 3'd4;
	localparam logic [2:0] E_EARLY     = 3'd5;

	localparam logic [1:0] LW_TRUE  = 2'd0;
	localparam logic [1:0] LW_FALSE = 2'd1;
	localparam logic [1:0] LW_NULL  = 2'd2;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UPPER_E = 8'h45;
	localparam logic [7:0] CH_LOWER_E = 8'h65;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_L      = 8'h6C;
	localparam logic [7:0] CH_S      = 8'h73;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       has_char;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [3:0] token_kind;
		logic       has_text;
		logic [7:0] text_byte;
		logic       token_end;
		logic [2:0] error_code;
		logic       last_of_run;
	} res_t;

	typedef struct packed {
		res_t r0;
		res_t r1;
		logic v0;
		logic v1;
	} lex_out_t;

	localparam res_t RES_NONE = '0;

	function automatic res_t mk_tok(input logic [3:0] kind);
		res_t r;
		r = RES_NONE;
		r.token_kind = kind;
		r.token_end = 1'b1;
		return r;
	endfunction

	function automatic res_t mk_text(input logic [3:0] kind, input logic [7:0] c);
		res_t r;
		r = RES_NONE;
		r.token_kind = kind;
		r.has_text = 1'b1;
		r.text_byte = c;
		return r;
	endfunction

	function automatic res_t mk_err(input logic [2:0] code);
		res_t r;
		r = RES_NONE;
		r.token_kind = K_ERROR;
		r.token_end = 1'b1;
		r.error_code = code;
		return r;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] w);
		return (w == LW_FALSE) ? 3'd4 : 3'd3;
	endfunction

	function automatic logic [3:0] lit_kind(input logic [1:0] w);
		logic [3:0] k;
		case (w)
			LW_TRUE:  k = K_TRUE;
			LW_FALSE: k = K_FALSE;
			default:  k = K_NULL;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [1:0] p);
		logic [7:0] ch;
		case (w)
			LW_TRUE: begin
				case (p)
					2'd0:    ch = CH_R;
					2'd1:    ch = CH_U;
					2'd2:    ch = CH_LOWER_E;
					default: ch = 8'h00;
				endcase
			end
			LW_FALSE: begin
				case (p)
					2'd0:    ch = CH_A;
					2'd1:    ch = CH_L;
					2'd2:    ch = CH_S;
					default: ch = CH_LOWER_E;
				endcase
			end
			default: begin
				case (p)
					2'd0:    ch = CH_U;
					2'd1:    ch = CH_L;
					2'd2:    ch = CH_L;
					default: ch = 8'h00;
				endcase
			end
		endcase
		return ch;
	endfunction

endpackage

>>> design/json_token_lexer.sv
// JSON lexer taking one byte item per cycle while its results drain. Input byte items
// go through an input register into the lexer state logic, whose results land in a
// two-entry result register. An item that yields at most one result is taken every
// cycle while the output is ready; an item that yields two results (a number closed
// by the byte that follows it, or a content byte followed by end of text) makes later
// items wait while the result register drains its pair. s_axis_tlast marks end of
// text, s_axis_tuser flags a valid byte (clear for an end-only item), and m_axis_tlast
// marks the last result of an input item.
module json_token_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_byte
	input  logic [0:0]  s_axis_tuser,  // [0] has_char
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] text_byte, [8] token_end, [11:9] error_code
	output logic [4:0]  m_axis_tuser,  // [3:0] token_kind, [4] has_text
	output logic        m_axis_tlast
);
	import jtl_pkg::*;

	item_t    in_item, item_s1;
	logic     item_valid_s1, adv;
	lex_out_t lex_out;
	res_t     out_res;

	assign in_item.char_byte   = s_axis_tdata;
	assign in_item.has_char    = s_axis_tuser[0];
	assign in_item.end_of_text = s_axis_tlast;

	jtl_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_item       (in_item),
		.take          (adv),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	jtl_lex_core u_lex_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.adv     (adv),
		.lex_out (lex_out)
	);

	jtl_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid_s1),
		.lex_out    (lex_out),
		.adv        (adv),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	assign m_axis_tdata = {4'b0000, out_res.error_code, out_res.token_end, out_res.text_byte};
	assign m_axis_tuser = {out_res.has_text, out_res.token_kind};
	assign m_axis_tlast = out_res.last_of_run;

endmodule

>>> design/jtl_in_stage.sv
module jtl_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  jtl_pkg::item_t in_item,
	input  logic           take,
	output logic           item_valid_s1,
	output jtl_pkg::item_t item_s1
);
	import jtl_pkg::*;

	assign in_ready = !item_valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			item_valid_s1 <= 1'b1;
		end else if (take) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> design/jtl_lex_core.sv
`include "assert_macros.svh"

module jtl_lex_core (
	input  logic              clk,
	input  logic              arst_n,
	input  jtl_pkg::item_t    item,
	input  logic              adv,
	output jtl_pkg::lex_out_t lex_out
);
	import jtl_pkg::*;

	logic [MODE_W-1:0] mode_q, mode_b, mode_n;
	logic [2:0]        lpos_q, lpos_b, lpos_n, lpos_inc;
	logic [1:0]        lwhich_q, lwhich_b, lwhich_n;
	logic              pbs_q, pbs_b, pbs_n;
	logic              err_q, err_b, err_n;

	logic [7:0] c;
	logic       is_dig, is_exp, close, idle_run;
	logic       a_v, b_v, e_v, i_v;
	res_t       a, b, e, ir;
	res_t       r0, r1;

	assign c        = item.char_byte;
	assign is_dig   = c inside {[CH_ZERO:CH_NINE]};
	assign is_exp   = c inside {CH_UPPER_E, CH_LOWER_E};
	assign lpos_inc = lpos_q + 3'd1;

	always_comb begin
		mode_b   = mode_q;
		lpos_b   = lpos_q;
		lwhich_b = lwhich_q;
		pbs_b    = pbs_q;
		err_b    = err_q;
		a_v      = 1'b0;
		a        = RES_NONE;
		b_v      = 1'b0;
		b        = RES_NONE;
		i_v      = 1'b0;
		ir       = RES_NONE;
		close    = 1'b0;
		idle_run = 1'b0;
		if (item.has_char && !err_q) begin
			case (mode_q)
				M_LIT: begin
					if (lpos_q < lit_len(lwhich_q) && lit_char(lwhich_q, lpos_q[1:0]) == c) begin
						if (lpos_inc >= lit_len(lwhich_q)) begin
							a_v    = 1'b1;
							a      = mk_tok(lit_kind(lwhich_q));
							mode_b = M_IDLE;
							lpos_b = 3'd0;
						end else begin
							lpos_b = lpos_inc;
						end
					end else begin
						a_v = 1'b1; a = mk_err(E_BAD_LIT); err_b = 1'b1; mode_b = M_IDLE;
					end
				end
				M_STR: begin
					a_v = 1'b1;
					if (c == CH_QUOTE && !pbs_q) begin
						a      = mk_tok(K_STRING);
						mode_b = M_IDLE;
					end else begin
						a     = mk_text(K_STRING, c);
						pbs_b = (c == CH_BSLASH) && !pbs_q;
					end
				end
				M_MINUS: begin
					a_v = 1'b1;
					if (is_dig) begin
						a      = mk_text(K_NUMBER, c);
						mode_b = (c == CH_ZERO) ? M_ZERO : M_INT;
					end else begin
						a = mk_err(E_DIGIT); err_b = 1'b1; mode_b = M_IDLE;
					end
				end
				M_ZERO, M_INT: begin
					if (mode_q == M_INT && is_dig) begin
						a_v = 1'b1; a = mk_text(K_NUMBER, c);
					end else if (c == CH_DOT) begin
						a_v = 1'b1; a = mk_text(K_NUMBER, c); mode_b = M_DOT;
					end else if (is_exp) begin
						a_v = 1'b1; a = mk_text(K_NUMBER, c); mode_b = M_EXPE;
					end else begin
						close = 1'b1;
					end
				end
				M_DOT: begin
					a_v = 1'b1;
					if (is_dig) begin
						a = mk_text(K_NUMBER, c); mode_b = M_FRAC;
					end else begin
						a = mk_err(E_DIGIT); err_b = 1'b1; mode_b = M_IDLE;
					end
				end
				M_FRAC: begin
					if (is_dig) begin
						a_v = 1'b1; a = mk_text(K_NUMBER, c);
					end else if (is_exp) begin
						a_v = 1'b1; a = mk_text(K_NUMBER, c); mode_b = M_EXPE;
					end else begin
						close = 1'b1;
					end
				end
				M_EXPE: begin
					a_v = 1'b1;
					if (c inside {CH_PLUS, CH_MINUS}) begin
						a = mk_text(K_NUMBER, c); mode_b = M_ESIGN;
					end else begin
						a = mk_err(E_SIGN); err_b = 1'b1; mode_b = M_IDLE;
					end
				end
				M_ESIGN: begin
					a_v = 1'b1;
					if (is_dig) begin
						a = mk_text(K_NUMBER, c); mode_b = M_EXPD;
					end else begin
						a = mk_err(E_DIGIT); err_b = 1'b1; mode_b = M_IDLE;
					end
				end
				M_EXPD: begin
					if (is_dig) begin
						a_v = 1'b1; a = mk_text(K_NUMBER, c);
					end else begin
						close = 1'b1;
					end
				end
				default: begin
					mode_b   = M_IDLE;
					idle_run = 1'b1;
				end
			endcase
			if (close) begin
				a_v    = 1'b1;
				a      = mk_tok(K_NUMBER);
				mode_b = M_IDLE;
				if (c == CH_MINUS || is_dig) begin
					b_v = 1'b1; b = mk_err(E_BAD_START); err_b = 1'b1;
				end else begin
					idle_run = 1'b1;
				end
			end
			if (idle_run) begin
				if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
					i_v = 1'b0;
				end else if (c == CH_LBRACE) begin
					i_v = 1'b1; ir = mk_tok(K_LBRACE);
				end else if (c == CH_RBRACE) begin
					i_v = 1'b1; ir = mk_tok(K_RBRACE);
				end else if (c == CH_LBRACK) begin
					i_v = 1'b1; ir = mk_tok(K_LBRACK);
				end else if (c == CH_RBRACK) begin
					i_v = 1'b1; ir = mk_tok(K_RBRACK);
				end else if (c == CH_COLON) begin
					i_v = 1'b1; ir = mk_tok(K_COLON);
				end else if (c == CH_COMMA) begin
					i_v = 1'b1; ir = mk_tok(K_COMMA);
				end else if (c inside {CH_T, CH_F, CH_N}) begin
					lwhich_b = (c == CH_T) ? LW_TRUE : ((c == CH_F) ? LW_FALSE : LW_NULL);
					lpos_b   = 3'd0;
					mode_b   = M_LIT;
				end else if (c == CH_QUOTE) begin
					pbs_b  = 1'b0;
					mode_b = M_STR;
				end else if (c == CH_MINUS) begin
					i_v = 1'b1; ir = mk_text(K_NUMBER, c); mode_b = M_MINUS;
				end else if (is_dig) begin
					i_v    = 1'b1;
					ir     = mk_text(K_NUMBER, c);
					mode_b = (c == CH_ZERO) ? M_ZERO : M_INT;
				end else begin
					i_v = 1'b1; ir = mk_err(E_BAD_START); err_b = 1'b1; mode_b = M_IDLE;
				end
				if (close) begin
					b_v = i_v; b = ir;
				end else begin
					a_v = i_v; a = ir;
				end
			end
		end
	end

	always_comb begin
		e_v = 1'b0;
		e   = RES_NONE;
		if (item.end_of_text && !err_b) begin
			case (mode_b)
				M_STR: begin
					e_v = 1'b1; e = mk_tok(K_STRING);
				end
				M_ZERO, M_INT, M_FRAC, M_EXPD: begin
					e_v = 1'b1; e = mk_tok(K_NUMBER);
				end
				M_LIT, M_MINUS, M_DOT, M_EXPE, M_ESIGN: begin
					e_v = 1'b1; e = mk_err(E_EARLY);
				end
				default: e_v = 1'b0;
			endcase
		end
	end

	always_comb begin
		r0 = a_v ? a : (b_v ? b : e);
		r1 = (a_v && b_v) ? b : e;
		lex_out.v0 = a_v || b_v || e_v;
		lex_out.v1 = (a_v && b_v) || (a_v && e_v) || (b_v && e_v);
		if (lex_out.v1) begin
			r1.last_of_run = 1'b1;
		end else begin
			r0.last_of_run = 1'b1;
		end
		lex_out.r0 = r0;
		lex_out.r1 = r1;
	end

	always_comb begin
		if (item.end_of_text) begin
			mode_n   = M_IDLE;
			lpos_n   = 3'd0;
			lwhich_n = 2'd0;
			pbs_n    = 1'b0;
			err_n    = 1'b0;
		end else begin
			mode_n   = mode_b;
			lpos_n   = lpos_b;
			lwhich_n = lwhich_b;
			pbs_n    = pbs_b;
			err_n    = err_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			lpos_q   <= 3'd0;
			lwhich_q <= 2'd0;
			pbs_q    <= 1'b0;
			err_q    <= 1'b0;
		end else if (adv) begin
			mode_q   <= mode_n;
			lpos_q   <= lpos_n;
			lwhich_q <= lwhich_n;
			pbs_q    <= pbs_n;
			err_q    <= err_n;
		end
	end

	`ASSERT_PROP(a_err_idle, clk, arst_n, err_q |-> (mode_q == M_IDLE), "error held outside idle")
	`ASSERT_PROP(a_end_clears, clk, arst_n, (adv && item.end_of_text) |=> (!err_q && mode_q == M_IDLE), "end of text did not clear state")
	`ASSERT_NEVER(a_lpos_range, clk, arst_n, lpos_q > 3'd4, "literal position out of range")

endmodule

>>> design/jtl_out_buf.sv
`include "assert_macros.svh"

module jtl_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  jtl_pkg::lex_out_t lex_out,
	output logic              adv,
	output logic              out_valid,
	input  logic              out_ready,
	output jtl_pkg::res_t     out_res
);
	import jtl_pkg::*;

	logic [1:0] cnt_q;
	res_t       slot0_q, slot1_q;
	logic       pop;

	assign out_valid = cnt_q != 2'd0;
	assign out_res   = (cnt_q == 2'd2) ? slot0_q : slot1_q;
	assign pop       = out_valid && out_ready;
	assign adv       = item_valid && (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_ready));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (adv && lex_out.v0) begin
			cnt_q <= lex_out.v1 ? 2'd2 : 2'd1;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && lex_out.v0) begin
			if (lex_out.v1) begin
				slot0_q <= lex_out.r0;
				slot1_q <= lex_out.r1;
			end else begin
				slot1_q <= lex_out.r0;
			end
		end
	end

	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q == 2'd3, "result count overflow")
	`ASSERT_PROP(a_second_needs_first, clk, arst_n, lex_out.v1 |-> lex_out.v0, "second result without first")
	`ASSERT_PROP(a_pair_loaded, clk, arst_n, (adv && lex_out.v1) |=> (cnt_q == 2'd2), "result pair not held")

endmodule

>>> tb/json_token_lexer_tb.sv
`timescale 1ns / 100ps

module json_token_lexer_tb;

	import jtl_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int IDLE_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 1750;
	localparam int DRAIN_EVERY = 400;

	typedef struct {
		item_t item;
		bit    typed;
		bit    has_want;
		res_t  want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [4:0]  m_axis_tuser;
	logic        m_axis_tlast;

	logic [MODE_W-1:0] lx_mode;
	logic [2:0]        lit_pos;
	logic [1:0]        lit_sel;
	bit                esc_pending;
	bit                err_hold;

	res_t  step_res[$];
	res_t  tokens_due[$];
	row_t  script[$];
	item_t text_q[$];
	int    fails = 0;
	int    calm_left = 0;
	int    stall_left = 0;
	int    idle_cycles = 0;

	json_token_lexer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic void clear_state();
		lx_mode = M_IDLE;
		lit_pos = '0;
		lit_sel = '0;
		esc_pending = 1'b0;
		err_hold = 1'b0;
	endfunction

	function automatic void add_tok(input logic [3:0] kind, input bit txt, input logic [7:0] c,
			input bit tend, input logic [2:0] err);
		res_t r;
		if (step_res.size() >= 2)
			return;
		r = RES_NONE;
		r.token_kind = kind;
		r.has_text = txt;
		r.text_byte = txt ? c : 8'h00;
		r.token_end = tend;
		r.error_code = err;
		step_res.insert(step_res.size(), r);
	endfunction

	function automatic void num_text(input logic [7:0] c);
		add_tok(K_NUMBER, 1'b1, c, 1'b0, E_NONE);
	endfunction

	function automatic void raise_err(input logic [2:0] code);
		add_tok(K_ERROR, 1'b0, 8'h00, 1'b1, code);
		err_hold = 1'b1;
		lx_mode = M_IDLE;
	endfunction

	function automatic void start_token(input logic [7:0] c);
		case (c)
			CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
			CH_LBRACE: add_tok(K_LBRACE, 1'b0, 8'h00, 1'b1, E_NONE);
			CH_RBRACE: add_tok(K_RBRACE, 1'b0, 8'h00, 1'b1, E_NONE);
			CH_LBRACK: add_tok(K_LBRACK, 1'b0, 8'h00, 1'b1, E_NONE);
			CH_RBRACK: add_tok(K_RBRACK, 1'b0, 8'h00, 1'b1, E_NONE);
			CH_COLON:  add_tok(K_COLON, 1'b0, 8'h00, 1'b1, E_NONE);
			CH_COMMA:  add_tok(K_COMMA, 1'b0, 8'h00, 1'b1, E_NONE);
			CH_T, CH_F, CH_N: begin
				lit_sel = (c == CH_T) ? LW_TRUE : ((c == CH_F) ? LW_FALSE : LW_NULL);
				lit_pos = '0;
				lx_mode = M_LIT;
			end
			CH_QUOTE: begin
				esc_pending = 1'b0;
				lx_mode = M_STR;
			end
			CH_MINUS: begin
				num_text(c);
				lx_mode = M_MINUS;
			end
			default: begin
				if (is_digit(c)) begin
					num_text(c);
					lx_mode = (c == CH_ZERO) ? M_ZERO : M_INT;
				end else begin
					raise_err(E_BAD_START);
				end
			end
		endcase
	endfunction

	function automatic void end_number(input logic [7:0] c);
		add_tok(K_NUMBER, 1'b0, 8'h00, 1'b1, E_NONE);
		lx_mode = M_IDLE;
		if (c == CH_MINUS || is_digit(c))
			raise_err(E_BAD_START);
		else
			start_token(c);
	endfunction

	function automatic void lex_item(input item_t it);
		logic [7:0] c;
		logic [3:0] kind;
		bit         exp_mark;
		string      tail;
		int         idx;
		c = it.char_byte;
		exp_mark = (c == CH_LOWER_E) || (c == CH_UPPER_E);
		step_res.delete();
		if (it.has_char && !err_hold) begin
			case (lx_mode)
				M_LIT: begin
					case (lit_sel)
						LW_TRUE:  tail = "rue";
						LW_FALSE: tail = "alse";
						default:  tail = "ull";
					endcase
					if (lit_pos < tail.len() && tail[lit_pos] == c) begin
						lit_pos++;
						if (lit_pos >= tail.len()) begin
							case (lit_sel)
								LW_TRUE:  kind = K_TRUE;
								LW_FALSE: kind = K_FALSE;
								default:  kind = K_NULL;
							endcase
							add_tok(kind, 1'b0, 8'h00, 1'b1, E_NONE);
							lx_mode = M_IDLE;
							lit_pos = '0;
						end
					end else begin
						raise_err(E_BAD_LIT);
					end
				end
				M_STR: begin
					if (c == CH_QUOTE && !esc_pending) begin
						add_tok(K_STRING, 1'b0, 8'h00, 1'b1, E_NONE);
						lx_mode = M_IDLE;
					end else begin
						add_tok(K_STRING, 1'b1, c, 1'b0, E_NONE);
						esc_pending = (c == CH_BSLASH) && !esc_pending;
					end
				end
				M_MINUS: begin
					if (is_digit(c)) begin
						num_text(c);
						lx_mode = (c == CH_ZERO) ? M_ZERO : M_INT;
					end else begin
						raise_err(E_DIGIT);
					end
				end
				M_ZERO, M_INT: begin
					if (lx_mode == M_INT && is_digit(c)) begin
						num_text(c);
					end else if (c == CH_DOT) begin
						num_text(c);
						lx_mode = M_DOT;
					end else if (exp_mark) begin
						num_text(c);
						lx_mode = M_EXPE;
					end else begin
						end_number(c);
					end
				end
				M_DOT: begin
					if (is_digit(c)) begin
						num_text(c);
						lx_mode = M_FRAC;
					end else begin
						raise_err(E_DIGIT);
					end
				end
				M_FRAC: begin
					if (is_digit(c)) begin
						num_text(c);
					end else if (exp_mark) begin
						num_text(c);
						lx_mode = M_EXPE;
					end else begin
						end_number(c);
					end
				end
				M_EXPE: begin
					if (c == CH_PLUS || c == CH_MINUS) begin
						num_text(c);
						lx_mode = M_ESIGN;
					end else begin
						raise_err(E_SIGN);
					end
				end
				M_ESIGN: begin
					if (is_digit(c)) begin
						num_text(c);
						lx_mode = M_EXPD;
					end else begin
						raise_err(E_DIGIT);
					end
				end
				M_EXPD: begin
					if (is_digit(c))
						num_text(c);
					else
						end_number(c);
				end
				default: begin
					lx_mode = M_IDLE;
					start_token(c);
				end
			endcase
		end
		if (it.end_of_text) begin
			if (!err_hold) begin
				case (lx_mode)
					M_STR: add_tok(K_STRING, 1'b0, 8'h00, 1'b1, E_NONE);
					M_ZERO, M_INT, M_FRAC, M_EXPD: add_tok(K_NUMBER, 1'b0, 8'h00, 1'b1, E_NONE);
					M_LIT, M_MINUS, M_DOT, M_EXPE, M_ESIGN: raise_err(E_EARLY);
					default: ;
				endcase
			end
			clear_state();
		end
		if (step_res.size() > 0) begin
			idx = step_res.size() - 1;
			step_res[idx].last_of_run = 1'b1;
		end
	endfunction

	function automatic res_t done_tok(input logic [3:0] kind, input logic [2:0] err);
		res_t r;
		r = RES_NONE;
		r.token_kind = kind;
		r.token_end = 1'b1;
		r.error_code = err;
		r.last_of_run = 1'b1;
		return r;
	endfunction

	function automatic void add_row(input logic [7:0] c, input bit hc, input bit eot,
			input bit typed = 1'b0, input bit has_want = 1'b0, input res_t want = RES_NONE);
		row_t row;
		row.item = item_t'{char_byte: c, has_char: hc, end_of_text: eot};
		row.typed = typed;
		row.has_want = has_want;
		row.want = want;
		script.insert(script.size(), row);
	endfunction

	function automatic void put_byte(input logic [7:0] c);
		text_q.insert(text_q.size(), item_t'{char_byte: c, has_char: 1'b1, end_of_text: 1'b0});
	endfunction

	function automatic void put_ws();
		int n;
		n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: put_byte(CH_SPACE);
				1: put_byte(CH_TAB);
				2: put_byte(CH_CR);
				default: put_byte(CH_LF);
			endcase
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95) begin
			calm_left = $urandom_range(30, 120);
			return 0;
		end
		return $urandom_range(8, 25);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fails++;
		end
	endfunction

	task automatic send_item(input item_t it, input bit drain, input bit typed = 1'b0,
			input bit has_want = 1'b0, input res_t want = RES_NONE);
		int gap;
		gap = pick_gap();
		if (drain && gap == 0)
			gap = 1;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (drain && tokens_due.size() != 0) @(posedge clk);
		end
		s_axis_tdata <= it.char_byte;
		s_axis_tuser <= it.has_char;
		s_axis_tlast <= it.end_of_text;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		lex_item(it);
		if (typed) begin
			if (has_want)
				tokens_due.insert(tokens_due.size(), want);
		end else begin
			foreach (step_res[k])
				tokens_due.insert(tokens_due.size(), step_res[k]);
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (m_axis_tready) begin
			m_axis_tready <= 1'b0;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 2);
		end else begin
			m_axis_tready <= 1'b1;
			stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(0, 12);
		end
	end

	always @(posedge clk) begin
		res_t head;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (tokens_due.size() == 0) begin
				$error("token_kind: expected no result, got %0d", m_axis_tuser[3:0]);
				fails++;
			end else begin
				head = tokens_due.pop_front();
				check_field("token_kind", 8'(head.token_kind), 8'(m_axis_tuser[3:0]));
				check_field("has_text", 8'(head.has_text), 8'(m_axis_tuser[4]));
				check_field("text_byte", head.text_byte, m_axis_tdata[7:0]);
				check_field("token_end", 8'(head.token_end), 8'(m_axis_tdata[8]));
				check_field("error_code", 8'(head.error_code), 8'(m_axis_tdata[11:9]));
				check_field("last_of_run", 8'(head.last_of_run), 8'(m_axis_tlast));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		item_t      blank;
		string      word;
		logic [7:0] c;
		int         i;
		int         j;
		int         n;
		int         idx;
		int         doc_start;
		int         counted;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		clear_state();

		add_row(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
		add_row(CH_LBRACE, 1'b1, 1'b0, 1'b1, 1'b1, done_tok(K_LBRACE, E_NONE));
		add_row(CH_SPACE, 1'b1, 1'b0);
		add_row(CH_QUOTE, 1'b1, 1'b0);
		add_row(CH_BSLASH, 1'b1, 1'b0);
		add_row(CH_QUOTE, 1'b1, 1'b0);
		add_row(CH_BSLASH, 1'b1, 1'b0);
		add_row(CH_BSLASH, 1'b1, 1'b0);
		add_row(CH_QUOTE, 1'b1, 1'b0);
		add_row(CH_COLON, 1'b1, 1'b0, 1'b1, 1'b1, done_tok(K_COLON, E_NONE));
		add_row(CH_MINUS, 1'b1, 1'b0);
		add_row(CH_ZERO, 1'b1, 1'b0);
		add_row(CH_DOT, 1'b1, 1'b0);
		add_row(CH_ZERO + 8'd5, 1'b1, 1'b0);
		add_row(CH_UPPER_E, 1'b1, 1'b0);
		add_row(CH_PLUS, 1'b1, 1'b0);
		add_row(CH_NINE, 1'b1, 1'b0);
		add_row(CH_RBRACK, 1'b1, 1'b0);
		add_row(CH_N, 1'b1, 1'b0);
		add_row(CH_U, 1'b1, 1'b0);
		add_row(CH_L, 1'b1, 1'b0);
		add_row(CH_L, 1'b1, 1'b0);
		add_row(CH_COMMA, 1'b1, 1'b0, 1'b1, 1'b1, done_tok(K_COMMA, E_NONE));
		add_row(CH_ZERO + 8'd7, 1'b1, 1'b0);
		add_row(CH_MINUS, 1'b1, 1'b0);
		add_row(8'hFF, 1'b1, 1'b1);
		add_row(CH_F, 1'b1, 1'b0);
		add_row(CH_A, 1'b1, 1'b1, 1'b1, 1'b1, done_tok(K_ERROR, E_EARLY));
		add_row(CH_ZERO + 8'd1, 1'b1, 1'b0);
		add_row(CH_LOWER_E, 1'b1, 1'b0);
		add_row(8'h78, 1'b1, 1'b1, 1'b1, 1'b1, done_tok(K_ERROR, E_SIGN));
		add_row(CH_MINUS, 1'b1, 1'b0);
		add_row(CH_A, 1'b1, 1'b1, 1'b1, 1'b1, done_tok(K_ERROR, E_DIGIT));
		add_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, done_tok(K_ERROR, E_BAD_START));
		add_row(CH_QUOTE, 1'b1, 1'b0);
		add_row(8'h80, 1'b1, 1'b1);

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			doc_start = text_q.size();
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 10))
					text_q.insert(text_q.size(), item_t'{char_byte: 8'($urandom),
						has_char: ($urandom_range(0, 4) != 0), end_of_text: 1'b0});
			end else begin
				if ($urandom_range(0, 3) == 0)
					put_ws();
				repeat ($urandom_range(1, 12)) begin
					case ($urandom_range(0, 9))
						0, 1, 2: begin
							case ($urandom_range(0, 5))
								0: put_byte(CH_LBRACE);
								1: put_byte(CH_RBRACE);
								2: put_byte(CH_LBRACK);
								3: put_byte(CH_RBRACK);
								4: put_byte(CH_COLON);
								default: put_byte(CH_COMMA);
							endcase
						end
						3, 4: begin
							case ($urandom_range(0, 2))
								0: word = "true";
								1: word = "false";
								default: word = "null";
							endcase
							for (j = 0; j < word.len(); j++)
								put_byte(word[j]);
						end
						5, 6: begin
							put_byte(CH_QUOTE);
							repeat ($urandom_range(0, 8)) begin
								if ($urandom_range(0, 4) == 0) begin
									put_byte(CH_BSLASH);
									case ($urandom_range(0, 2))
										0: put_byte(CH_QUOTE);
										1: put_byte(CH_BSLASH);
										default: put_byte(8'($urandom));
									endcase
								end else begin
									c = 8'($urandom);
									if (c == CH_QUOTE || c == CH_BSLASH)
										c = c ^ 8'h01;
									put_byte(c);
								end
							end
							put_byte(CH_QUOTE);
						end
						default: begin
							if ($urandom_range(0, 2) == 0)
								put_byte(CH_MINUS);
							if ($urandom_range(0, 3) == 0) begin
								put_byte(CH_ZERO);
							end else begin
								put_byte(CH_ZERO + 8'($urandom_range(1, 9)));
								repeat ($urandom_range(0, 4))
									put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
							end
							if ($urandom_range(0, 2) == 0) begin
								put_byte(CH_DOT);
								repeat ($urandom_range(1, 3))
									put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
							end
							if ($urandom_range(0, 3) == 0) begin
								put_byte($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
								put_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
								repeat ($urandom_range(1, 3))
									put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
							end
						end
					endcase
					put_ws();
				end
				if ($urandom_range(0, 9) == 0) begin
					n = $urandom_range(1, 3);
					while (n > 0 && text_q.size() > doc_start + 1) begin
						void'(text_q.pop_back());
						n--;
					end
				end
				if ($urandom_range(0, 7) == 0) begin
					idx = $urandom_range(doc_start, text_q.size() - 1);
					text_q[idx].char_byte = 8'($urandom);
				end
			end
			if ($urandom_range(0, 2) == 0)
				text_q[text_q.size() - 1].end_of_text = 1'b1;
			else
				text_q.insert(text_q.size(), item_t'{char_byte: 8'($urandom), has_char: 1'b0,
					end_of_text: 1'b1});
			counted += text_q.size() - doc_start;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_item(script[i].item, 1'b0, script[i].typed, script[i].has_want, script[i].want);

		for (i = 0; i < text_q.size(); i++) begin
			if ($urandom_range(0, 39) == 0) begin
				blank = item_t'{char_byte: 8'($urandom), has_char: 1'b0, end_of_text: 1'b0};
				send_item(blank, 1'b0);
			end
			send_item(text_q[i], (i % DRAIN_EVERY) == 0);
		end
		s_axis_tvalid <= 1'b0;

		while (tokens_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
